/* hdl/pdm_pkg.sv */
// Shared constants, codes and types for the PWM period and duty measurement block.
package pdm_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam int TICK_OUT_W  = 16;
    localparam int DUTY_W      = 16;
    localparam int PRESCALE_W  = 3;
    localparam int BUS_CLOCK_W = 27;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 27;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_CLOCK  = 2'd2;

    localparam logic [DUTY_W-1:0]      FULL_SCALE_RST = 16'd255;
    localparam logic [PRESCALE_W-1:0]  PRESCALE_RST   = 3'd0;
    localparam logic [BUS_CLOCK_W-1:0] BUS_CLOCK_RST  = 27'd48000000;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_PER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT      = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } pdm_div_stat_t;

endpackage

/* hdl/pdm_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module pdm_div
    import pdm_pkg::*;
#(
    parameter int DW = 32,
    parameter int VW = 23
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output pdm_div_stat_t stat,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [VW-1:0] rem_next;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] quo_next;
    logic [VW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (!diff[VW])
        begin
            rem_next = diff[VW-1:0];
            quo_next = {quo_reg[DW-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg <= '0;
                quo_reg <= dividend;
                dsr_reg <= divisor;
                cnt_reg <= CW'(DW);
            end
            else if (cnt_reg != '0)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !stat.busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cnt_reg == CW'(1)))
        else $error("divider done without final step");
    a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.busy && dsr_reg != '0) |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

/* hdl/pwm_period_duty_measure_core.sv */
// Top level: PWM period, pulse width, duty and frequency from captured edge stamps.
// The first pair after reset is only stored and gives no result. A zero period goes
// straight to the output state; a saturated width runs the shared radix-2 divider
// for frequency only; a normal beat multiplies, then divides for duty, then frequency.
// DW = max(16+TIMER_BITS, 27); in_stall holds new beats until the result is registered.
// Reset: async active low; clears the stored pair and loads register defaults.
module pwm_period_duty_measure_core
    import pdm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [TIMER_BITS-1:0]  rise_time,
    input  logic [TIMER_BITS-1:0]  fall_time,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [TICK_OUT_W-1:0]  period_ticks,
    output logic [TICK_OUT_W-1:0]  pulse_ticks,
    output logic [DUTY_W-1:0]      duty_value,
    output logic [BUS_CLOCK_W-1:0] freq_hz,
    output logic [STATUS_W-1:0]    status
);

    localparam int PW = DUTY_W + TIMER_BITS;
    localparam int DW = (PW > BUS_CLOCK_W) ? PW : BUS_CLOCK_W;
    localparam int VW = TIMER_BITS + (1 << PRESCALE_W) - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DUTY_GO,
        S_DUTY_WAIT,
        S_FREQ_GO,
        S_FREQ_WAIT,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [DUTY_W-1:0]      fs_reg;
    logic [PRESCALE_W-1:0]  ps_reg;
    logic [BUS_CLOCK_W-1:0] bus_reg;
    logic [TIMER_BITS-1:0]  prev_rise_reg;
    logic [TIMER_BITS-1:0]  prev_fall_reg;
    logic                   have_prev_reg;
    logic [TIMER_BITS-1:0]  period_reg;
    logic [TIMER_BITS-1:0]  width_reg;
    logic [PW-1:0]          prod_reg;
    logic [DUTY_W-1:0]      duty_reg;
    logic [BUS_CLOCK_W-1:0] freq_reg;
    logic [STATUS_W-1:0]    stat_reg;
    logic                   out_valid_reg;
    logic [TICK_OUT_W-1:0]  period_out_reg;
    logic [TICK_OUT_W-1:0]  pulse_out_reg;
    logic [DUTY_W-1:0]      duty_out_reg;
    logic [BUS_CLOCK_W-1:0] freq_out_reg;
    logic [STATUS_W-1:0]    status_out_reg;

    logic                   in_accept;
    logic                   out_free;
    logic [TIMER_BITS-1:0]  period_next;
    logic [TIMER_BITS-1:0]  width_next;
    logic                   div_start;
    logic [DW-1:0]          div_dividend;
    logic [VW-1:0]          div_divisor;
    logic [DW-1:0]          div_quotient;
    pdm_div_stat_t          div_stat;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign period_next = rise_time - prev_rise_reg;
    assign width_next  = prev_fall_reg - prev_rise_reg;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DW'(bus_reg);
        div_divisor  = VW'(period_reg) << ps_reg;
        unique case (state_reg)
            S_DUTY_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DW'(prod_reg);
                div_divisor  = VW'(period_reg);
            end
            S_FREQ_GO:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    pdm_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg  <= FULL_SCALE_RST;
            ps_reg  <= PRESCALE_RST;
            bus_reg <= BUS_CLOCK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FULL_SCALE: fs_reg  <= cfg_data[DUTY_W-1:0];
                REG_PRESCALE:   ps_reg  <= cfg_data[PRESCALE_W-1:0];
                REG_BUS_CLOCK:  bus_reg <= cfg_data[BUS_CLOCK_W-1:0];
                default:        fs_reg  <= fs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_rise_reg  <= '0;
            prev_fall_reg  <= '0;
            have_prev_reg  <= 1'b0;
            period_reg     <= '0;
            width_reg      <= '0;
            prod_reg       <= '0;
            duty_reg       <= '0;
            freq_reg       <= '0;
            stat_reg       <= ST_OK;
            out_valid_reg  <= 1'b0;
            period_out_reg <= '0;
            pulse_out_reg  <= '0;
            duty_out_reg   <= '0;
            freq_out_reg   <= '0;
            status_out_reg <= ST_OK;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        prev_rise_reg <= rise_time;
                        prev_fall_reg <= fall_time;
                        have_prev_reg <= 1'b1;
                        period_reg    <= period_next;
                        width_reg     <= width_next;
                        if (have_prev_reg)
                        begin
                            if (period_next == '0)
                            begin
                                stat_reg  <= ST_ZERO_PER;
                                duty_reg  <= '0;
                                freq_reg  <= '0;
                                state_reg <= S_OUT;
                            end
                            else if (width_next > period_next)
                            begin
                                stat_reg  <= ST_SAT;
                                duty_reg  <= fs_reg;
                                state_reg <= S_FREQ_GO;
                            end
                            else
                            begin
                                stat_reg  <= ST_OK;
                                state_reg <= S_MUL;
                            end
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= PW'(fs_reg) * PW'(width_reg);
                    state_reg <= S_DUTY_GO;
                end
                S_DUTY_GO:
                begin
                    state_reg <= S_DUTY_WAIT;
                end
                S_DUTY_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        duty_reg  <= div_quotient[DUTY_W-1:0];
                        state_reg <= S_FREQ_GO;
                    end
                end
                S_FREQ_GO:
                begin
                    state_reg <= S_FREQ_WAIT;
                end
                S_FREQ_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        freq_reg  <= div_quotient[BUS_CLOCK_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        period_out_reg <= TICK_OUT_W'(period_reg);
                        pulse_out_reg  <= TICK_OUT_W'(width_reg);
                        duty_out_reg   <= duty_reg;
                        freq_out_reg   <= freq_reg;
                        status_out_reg <= stat_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign period_ticks = period_out_reg;
    assign pulse_ticks  = pulse_out_reg;
    assign duty_value   = duty_out_reg;
    assign freq_hz      = freq_out_reg;
    assign status       = status_out_reg;

`ifndef SYNTHESIS
    a_zero_period_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_out_reg == ST_ZERO_PER) |->
        (duty_out_reg == '0 && freq_out_reg == '0))
        else $error("zero period result with nonzero duty or frequency");
    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside output state");
    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DUTY_WAIT || state_reg == S_FREQ_WAIT))
        else $error("divider finished while sequencer not waiting");
`endif

endmodule
